// File: rtl/core/acrd_pkg.sv
// Shared types, constants and helpers for the adaptive CDF range decoder.
// No dependencies.
package acrd_pkg;

    localparam int NUM_CONTEXTS = 1024;
    localparam int MAX_SYMBOLS  = 16;
    localparam int PROB_SHIFT   = 6;
    localparam int MIN_PROB     = 4;
    localparam int SLOTS        = 16;
    localparam int ADDR_W       = $clog2(NUM_CONTEXTS * SLOTS);
    localparam int CADDR_W      = $clog2(NUM_CONTEXTS);

    localparam logic [15:0] ONE_Q15  = 16'h8000;
    localparam logic [15:0] HALF_Q15 = 16'h4000;

    localparam logic [2:0] KIND_LOAD = 3'd0;
    localparam logic [2:0] KIND_READ = 3'd1;
    localparam logic [2:0] KIND_PUSH = 3'd2;
    localparam logic [2:0] KIND_INIT = 3'd3;
    localparam logic [2:0] KIND_SYM  = 3'd4;
    localparam logic [2:0] KIND_BOOL = 3'd5;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SHORT = 2'd1,
        ST_FULL  = 2'd2,
        ST_BAD   = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_EXEC,
        OP_RD_CAP,
        OP_FETCH,
        OP_WALK_INIT,
        OP_WALK,
        OP_RN1,
        OP_RN2,
        OP_ADAPT,
        OP_FINISH
    } t_dp_op;

    typedef struct packed {
        logic   latch;
        t_dp_op op;
    } t_cmd;

    typedef struct packed {
        logic [2:0] kind;
        logic       bad;
        logic       fetch_last;
        logic       walk_hit;
        logic       rn_short;
        logic       adapt_en;
        logic       adapt_last;
    } t_stat;

    function automatic logic [3:0] log2_floor16(input logic [15:0] v);
        logic [3:0] r;
        r = 4'd0;
        for (int i = 1; i < 16; i++) begin
            if (v[i]) r = 4'(i);
        end
        return r;
    endfunction

endpackage

// File: rtl/core/acrd_ctrl.sv
// Sequencer for the range decoder: steps the datapath through each word.
// Depends on acrd_pkg.
module acrd_ctrl import acrd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_RDWAIT, S_FETCH, S_FWAIT,
        S_WALK, S_RN1, S_RN2, S_ADAPT, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;

    always_comb begin
        n_state     = r_state;
        n_busy      = r_busy;
        o_cmd.latch = 1'b0;
        o_cmd.op    = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DISPATCH;
                    n_busy      = 1'b1;
                end
            end
            S_DISPATCH: begin
                o_cmd.op = OP_EXEC;
                if (i_stat.bad) n_state = S_DONE;
                else if (i_stat.kind == KIND_READ) n_state = S_RDWAIT;
                else if (i_stat.kind == KIND_SYM) n_state = S_FETCH;
                else if (i_stat.kind == KIND_BOOL) n_state = S_WALK;
                else n_state = S_DONE;
            end
            S_RDWAIT: begin
                o_cmd.op = OP_RD_CAP;
                n_state  = S_DONE;
            end
            S_FETCH: begin
                o_cmd.op = OP_FETCH;
                if (i_stat.fetch_last) n_state = S_FWAIT;
            end
            S_FWAIT: begin
                o_cmd.op = OP_WALK_INIT;
                n_state  = S_WALK;
            end
            S_WALK: begin
                o_cmd.op = OP_WALK;
                if (i_stat.walk_hit) n_state = S_RN1;
            end
            S_RN1: begin
                o_cmd.op = OP_RN1;
                n_state  = S_RN2;
            end
            S_RN2: begin
                o_cmd.op = OP_RN2;
                if (!i_stat.rn_short && i_stat.adapt_en) n_state = S_ADAPT;
                else n_state = S_DONE;
            end
            S_ADAPT: begin
                o_cmd.op = OP_ADAPT;
                if (i_stat.adapt_last) n_state = S_DONE;
            end
            S_DONE: begin
                o_cmd.op = OP_FINISH;
                n_state  = S_IDLE;
                n_busy   = 1'b0;
            end
            default: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign o_busy = r_busy;

endmodule

// File: rtl/core/acrd_dp.sv
// Datapath of the range decoder: context memories, bit buffer, range state,
// symbol search, renormalization and table adaptation. Depends on acrd_pkg.
module acrd_dp import acrd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    input  logic [2:0]  i_kind,
    input  logic [9:0]  i_context_req,
    input  logic [4:0]  i_num_symbols,
    input  logic [4:0]  i_entry_index,
    input  logic [15:0] i_entry_value,
    input  logic [15:0] i_bit_word,
    input  logic [23:0] i_tile_bytes,
    output logic        o_valid,
    output logic [3:0]  o_symbol,
    output logic [15:0] o_read_value,
    output logic [1:0]  o_status,
    output logic [6:0]  o_buffered_bits
);

    // memories
    logic [15:0] cdf_mem [NUM_CONTEXTS*SLOTS];
    logic [5:0]  ctr_mem [NUM_CONTEXTS];
    logic [15:0] r_mem_q;
    logic [5:0]  r_ctr_q;

    // item
    logic [2:0]  r_kind;
    logic [9:0]  r_ctx;
    logic [4:0]  r_n;
    logic [4:0]  r_entry;
    logic [15:0] r_evalue;
    logic [15:0] r_word;
    logic [23:0] r_bytes;

    // decoder state
    logic [15:0]        r_range, r_value;
    logic signed [31:0] r_bits_rem;
    logic [63:0]        r_buf;
    logic [6:0]         r_cnt;
    logic               r_disable;

    // work registers
    logic [15:0] r_tab [MAX_SYMBOLS];
    logic        r_cap_v;
    logic [3:0]  r_cap_i, r_fi, r_s, r_ai, r_sym, r_bits;
    logic [4:0]  r_nn;
    logic [5:0]  r_ctr;
    logic [15:0] r_cur, r_prev, r_nr, r_nv, r_rd;
    t_status     r_status;

    // output word
    logic        r_o_valid;
    logic [3:0]  r_o_symbol;
    logic [15:0] r_o_read;
    logic [1:0]  r_o_status;
    logic [6:0]  r_o_bits;

    t_dp_op op;
    logic   bad, is_ctr;
    assign op     = i_cmd.op;
    assign is_ctr = (r_entry == 5'(SLOTS));

    always_comb begin
        logic ctx_bad;
        ctx_bad = ({22'd0, r_ctx} >= 32'(NUM_CONTEXTS));
        if (r_kind == KIND_LOAD || r_kind == KIND_READ)
            bad = ctx_bad || (r_entry > 5'(SLOTS));
        else if (r_kind == KIND_SYM)
            bad = ctx_bad || (r_n < 5'd2) || (r_n > 5'(MAX_SYMBOLS));
        else
            bad = (r_kind > KIND_BOOL);
    end

    // bit extraction
    logic [3:0]  take_n, nb_init, nb_dec, avail;
    logic [6:0]  take_rest;
    logic [63:0] take_shift, take_buf;
    logic [15:0] take_got;
    logic [26:0] bytes8;
    logic        init_short, rn_short;

    assign bytes8  = {r_bytes, 3'b000};
    assign nb_init = (bytes8 < 27'd15) ? bytes8[3:0] : 4'd15;
    assign init_short = ({3'd0, nb_init} > r_cnt);

    always_comb begin
        if (r_bits_rem > 32'sd15) avail = 4'd15;
        else if (r_bits_rem > 32'sd0) avail = r_bits_rem[3:0];
        else avail = 4'd0;
    end
    assign nb_dec   = (r_bits < avail) ? r_bits : avail;
    assign rn_short = ({3'd0, nb_dec} > r_cnt);

    assign take_n     = (op == OP_EXEC) ? nb_init : nb_dec;
    assign take_rest  = r_cnt - {3'd0, take_n};
    assign take_shift = r_buf >> take_rest;
    assign take_got   = take_shift[15:0] & ((16'd1 << take_n) - 16'd1);
    assign take_buf   = r_buf & ~({64{1'b1}} << take_rest);

    // symbol search step
    logic [15:0] walk_f, walk_c;
    logic [23:0] walk_p, walk_sum;
    logic [4:0]  walk_k;
    logic        walk_last, walk_hit;
    assign walk_f    = ONE_Q15 - r_tab[r_s];
    assign walk_p    = 24'(r_range[15:8]) * 24'(walk_f >> PROB_SHIFT);
    assign walk_k    = r_nn - {1'b0, r_s} - 5'd1;
    assign walk_sum  = (walk_p >> (7 - PROB_SHIFT)) + 24'(MIN_PROB) * 24'(walk_k);
    assign walk_last = ({1'b0, r_s} == r_nn - 5'd1);
    assign walk_c    = walk_last ? 16'd0 : walk_sum[15:0];
    assign walk_hit  = (walk_c <= r_value);

    // renormalization
    logic [31:0]        rn_t;
    logic [15:0]        rn_val;
    logic signed [32:0] rn_rem;
    logic [31:0]        rn_rem_sat;
    assign rn_t   = (({16'd0, r_nv} + 32'd1) << r_bits) - 32'd1;
    assign rn_val = rn_t[15:0] ^ (take_got << (r_bits - nb_dec));
    assign rn_rem = {r_bits_rem[31], r_bits_rem} - $signed({29'd0, r_bits});
    assign rn_rem_sat = (rn_rem < $signed(33'h1_8000_0000)) ? 32'h8000_0000 : rn_rem[31:0];

    // adaptation
    logic [3:0]  ad_lg;
    logic [2:0]  ad_rate;
    logic [15:0] ad_c, ad_tgt, ad_new;
    assign ad_lg   = log2_floor16({11'd0, r_nn});
    assign ad_rate = 3'd3 + {2'd0, r_ctr > 6'd15} + {2'd0, r_ctr > 6'd31}
                   + ((ad_lg < 4'd2) ? ad_lg[2:0] : 3'd2);
    assign ad_c    = r_tab[r_ai];
    assign ad_tgt  = (r_ai >= r_sym) ? ONE_Q15 : 16'd0;
    assign ad_new  = (ad_tgt < ad_c) ? ad_c - ((ad_c - ad_tgt) >> ad_rate)
                                     : ad_c + ((ad_tgt - ad_c) >> ad_rate);

    logic adapt_last;
    assign adapt_last = ({1'b0, r_ai} == r_nn - 5'd2);

    // memory ports
    logic              mem_we, ctr_we;
    logic [3:0]        rd_idx, wr_idx;
    logic [15:0]       mem_wdata;
    logic [5:0]        ctr_wdata;
    logic [ADDR_W-1:0] mem_raddr, mem_waddr;
    logic              exec_load;
    assign exec_load = (op == OP_EXEC) && (r_kind == KIND_LOAD) && !bad;
    assign mem_we    = (exec_load && !is_ctr) || (op == OP_ADAPT);
    assign ctr_we    = (exec_load && is_ctr) ||
                       ((op == OP_ADAPT) && adapt_last && (r_ctr < 6'd32));
    assign wr_idx    = (op == OP_ADAPT) ? r_ai : r_entry[3:0];
    assign rd_idx    = (op == OP_FETCH) ? r_fi : r_entry[3:0];
    assign mem_wdata = (op == OP_ADAPT) ? ad_new : r_evalue;
    assign ctr_wdata = (op == OP_ADAPT) ? r_ctr + 6'd1 : r_evalue[5:0];
    assign mem_raddr = ADDR_W'({r_ctx, rd_idx});
    assign mem_waddr = ADDR_W'({r_ctx, wr_idx});

    always_ff @(posedge i_clk) begin
        if (mem_we) cdf_mem[mem_waddr] <= mem_wdata;
        r_mem_q <= cdf_mem[mem_raddr];
        if (ctr_we) ctr_mem[CADDR_W'(r_ctx)] <= ctr_wdata;
        r_ctr_q <= ctr_mem[CADDR_W'(r_ctx)];
    end

    // payload and work registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_kind   <= i_kind;
            r_ctx    <= i_context_req;
            r_n      <= i_num_symbols;
            r_entry  <= i_entry_index;
            r_evalue <= i_entry_value;
            r_word   <= i_bit_word;
            r_bytes  <= i_tile_bytes;
            r_sym    <= 4'd0;
            r_rd     <= 16'd0;
            r_status <= ST_OK;
        end
        if (r_cap_v) r_tab[r_cap_i] <= r_mem_q;
        r_cap_i <= r_fi;
        unique case (op)
            OP_EXEC: begin
                r_fi <= 4'd0;
                r_nn <= (r_kind == KIND_BOOL) ? 5'd2 : r_n;
                if (bad) begin
                    r_status <= ST_BAD;
                end else if (r_kind == KIND_PUSH && r_cnt > 7'd48) begin
                    r_status <= ST_FULL;
                end else if (r_kind == KIND_INIT && init_short) begin
                    r_status <= ST_SHORT;
                end else if (r_kind == KIND_BOOL) begin
                    r_tab[0] <= HALF_Q15;
                    r_cur    <= r_range;
                    r_s      <= 4'd0;
                end
            end
            OP_RD_CAP:    r_rd <= is_ctr ? {10'd0, r_ctr_q} : r_mem_q;
            OP_FETCH:     r_fi <= r_fi + 4'd1;
            OP_WALK_INIT: begin
                r_cur <= r_range;
                r_s   <= 4'd0;
                r_ctr <= r_ctr_q;
                r_ai  <= 4'd0;
            end
            OP_WALK: begin
                r_prev <= r_cur;
                r_cur  <= walk_c;
                if (walk_hit) r_sym <= r_s;
                else r_s <= r_s + 4'd1;
            end
            OP_RN1: begin
                r_nr   <= r_prev - r_cur;
                r_nv   <= r_value - r_cur;
                r_bits <= 4'd15 - log2_floor16(r_prev - r_cur);
                r_ai   <= 4'd0;
            end
            OP_RN2: begin
                if (rn_short) begin
                    r_status <= ST_SHORT;
                    r_sym    <= 4'd0;
                end
            end
            OP_ADAPT: r_ai <= r_ai + 4'd1;
            default: ;
        endcase
    end

    // decoder state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range    <= ONE_Q15;
            r_value    <= 16'd0;
            r_bits_rem <= 32'sd0;
            r_buf      <= 64'd0;
            r_cnt      <= 7'd0;
            r_disable  <= 1'b0;
            r_cap_v    <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) r_disable <= i_cfg_data;
            r_cap_v   <= (op == OP_FETCH);
            r_o_valid <= (op == OP_FINISH);
            if (op == OP_EXEC && !bad && r_kind == KIND_PUSH && r_cnt <= 7'd48) begin
                r_buf <= {r_buf[47:0], r_word};
                r_cnt <= r_cnt + 7'd16;
            end
            if (op == OP_EXEC && !bad && r_kind == KIND_INIT && !init_short) begin
                r_buf      <= take_buf;
                r_cnt      <= take_rest;
                r_value    <= 16'h7FFF ^ (take_got << (4'd15 - nb_init));
                r_range    <= ONE_Q15;
                r_bits_rem <= $signed({5'd0, bytes8}) - 32'sd15;
            end
            if (op == OP_RN2 && !rn_short) begin
                r_buf      <= take_buf;
                r_cnt      <= take_rest;
                r_range    <= r_nr << r_bits;
                r_value    <= rn_val;
                r_bits_rem <= $signed(rn_rem_sat);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (op == OP_FINISH) begin
            r_o_symbol <= r_sym;
            r_o_read   <= r_rd;
            r_o_status <= r_status;
            r_o_bits   <= r_cnt;
        end
    end

    assign o_stat.kind       = r_kind;
    assign o_stat.bad        = bad;
    assign o_stat.fetch_last = ({1'b0, r_fi} == r_nn - 5'd2);
    assign o_stat.walk_hit   = walk_hit;
    assign o_stat.rn_short   = rn_short;
    assign o_stat.adapt_en   = (r_kind == KIND_SYM) && !r_disable;
    assign o_stat.adapt_last = adapt_last;

    assign o_valid         = r_o_valid;
    assign o_symbol        = r_o_symbol;
    assign o_read_value    = r_o_read;
    assign o_status        = r_o_status;
    assign o_buffered_bits = r_o_bits;

endmodule

// File: rtl/core/adaptive_cdf_range_decoder.sv
// Adaptive CDF range decoder, top level. One word at a time; load, push, init and
// bad words give their result 3 cycles after start, read 4, bool decode up to 7.
// Symbol decode of an N-entry table takes at most 3N+4 cycles: the single port of
// the table memory fetches N-1 entries, the search takes up to N steps, and
// adaptation writes N-1 entries back. Reset is synchronous; no clearing pass,
// tables and counters hold garbage until loaded. Results cannot be stalled.
module adaptive_cdf_range_decoder import acrd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_kind,
    input  logic [9:0]  i_context_req,
    input  logic [4:0]  i_num_symbols,
    input  logic [4:0]  i_entry_index,
    input  logic [15:0] i_entry_value,
    input  logic [15:0] i_bit_word,
    input  logic [23:0] i_tile_bytes,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,
    output logic        o_valid,
    output logic [3:0]  o_symbol,
    output logic [15:0] o_read_value,
    output logic [1:0]  o_status,
    output logic [6:0]  o_buffered_bits
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = !busy;

    acrd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    acrd_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_we        (i_cfg_valid && o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_kind          (i_kind),
        .i_context_req   (i_context_req),
        .i_num_symbols   (i_num_symbols),
        .i_entry_index   (i_entry_index),
        .i_entry_value   (i_entry_value),
        .i_bit_word      (i_bit_word),
        .i_tile_bytes    (i_tile_bytes),
        .o_valid         (o_valid),
        .o_symbol        (o_symbol),
        .o_read_value    (o_read_value),
        .o_status        (o_status),
        .o_buffered_bits (o_buffered_bits)
    );

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("result while busy");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("accepted word did not raise busy");

    a_buf_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_buffered_bits <= 7'd64)) else $error("bit buffer overflow");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_symbol == 4'd0 && o_read_value == 16'd0))
        else $error("failed word carries data");

endmodule

// File: tb/sv/tb_top.sv
// Testbench for adaptive_cdf_range_decoder: table setup, directed corner words and
// random streams of words, checked against an in-bench model of the decoder.
// Depends on acrd_pkg and the decoder RTL.
module tb_top import acrd_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [3:0]  symbol;
        logic [15:0] read_value;
        logic [1:0]  status;
        logic [6:0]  buffered_bits;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  i_kind = '0;
    logic [9:0]  i_context_req = '0;
    logic [4:0]  i_num_symbols = '0;
    logic [4:0]  i_entry_index = '0;
    logic [15:0] i_entry_value = '0;
    logic [15:0] i_bit_word = '0;
    logic [23:0] i_tile_bytes = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_data = 1'b0;
    logic        o_valid;
    logic [3:0]  o_symbol;
    logic [15:0] o_read_value;
    logic [1:0]  o_status;
    logic [6:0]  o_buffered_bits;

    adaptive_cdf_range_decoder u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // decoder model state
    logic [15:0] cdf_mem [NUM_CONTEXTS*SLOTS];
    logic [5:0]  cnt_mem [NUM_CONTEXTS];
    bit          cdf_set [NUM_CONTEXTS*SLOTS];
    bit          cnt_set [NUM_CONTEXTS];
    int unsigned rng_q, val_q, bit_cnt;
    longint      bits_left;
    logic [63:0] bit_buf;
    bit          no_adapt;

    t_result     expected_q[$];
    int          errors = 0;
    int          gap_pct = 0;
    int          ctx_pool[4] = '{0, 1, 513, 1023};

    function automatic int unsigned log2_fl(int unsigned v);
        int unsigned r;
        r = 0;
        for (int i = 1; i < 16; i++) if (v[i]) r = i;
        return r;
    endfunction

    function automatic int unsigned pull_bits(int unsigned nb);
        int unsigned rest, got;
        if (nb == 0 || nb > bit_cnt) return 0;
        rest = bit_cnt - nb;
        got = int'((bit_buf >> rest) & ((64'd1 << nb) - 64'd1));
        bit_buf = (rest == 0) ? 64'd0 : (bit_buf & ((64'd1 << rest) - 64'd1));
        bit_cnt = rest;
        return got;
    endfunction

    // returns 1 when buffer bits are short
    function automatic bit decode_sym(input logic [15:0] tab [16], input int unsigned n,
                                      output int unsigned sym);
        int unsigned prev, cur, s, nr, nv, nbits, avail, nb, data, padded, f;
        longint rem;
        prev = rng_q;
        cur = rng_q;
        for (s = 0; s < n; s++) begin
            prev = cur;
            if (s + 1 == n) begin
                cur = 0;
            end else begin
                f = (32'h8000 - tab[s]) & 32'hFFFF;
                cur = ((rng_q >> 8) * (f >> PROB_SHIFT)) >> (7 - PROB_SHIFT);
                cur = (cur + MIN_PROB * (n - s - 1)) & 32'hFFFF;
            end
            if (cur <= val_q) break;
        end
        if (s >= n) s = n - 1;
        nr = (prev - cur) & 32'hFFFF;
        nv = (val_q - cur) & 32'hFFFF;
        nbits = 15 - log2_fl(nr);
        if (nbits > 0) begin
            avail = bits_left > 0 ? (bits_left > 15 ? 15 : int'(bits_left)) : 0;
            nb = nbits < avail ? nbits : avail;
            if (nb > bit_cnt) return 1'b1;
            nr = (nr << nbits) & 32'hFFFF;
            data = pull_bits(nb);
            padded = (data << (nbits - nb)) & 32'hFFFF;
            nv = ((((nv + 1) << nbits) - 1) ^ padded) & 32'hFFFF;
            rem = bits_left - nbits;
            if (rem < -64'sd2147483648) rem = -64'sd2147483648;
            bits_left = rem;
        end
        rng_q = nr;
        val_q = nv;
        sym = s;
        return 1'b0;
    endfunction

    function automatic void adapt_table(int unsigned ctx, int unsigned n, int unsigned sym);
        int unsigned cnt, lg, rate, target, c;
        cnt = cnt_mem[ctx];
        lg = log2_fl(n);
        rate = 3 + (cnt > 15) + (cnt > 31) + (lg < 2 ? lg : 2);
        target = 0;
        for (int unsigned i = 0; i + 1 < n; i++) begin
            c = cdf_mem[ctx*SLOTS + i];
            if (i == sym) target = 32'h8000;
            if (target < c) c -= (c - target) >> rate;
            else c += (target - c) >> rate;
            cdf_mem[ctx*SLOTS + i] = c[15:0];
        end
        if (cnt < 32) cnt_mem[ctx] = 6'(cnt + 1);
    endfunction

    function automatic t_result predict_word(logic [2:0] kind, int unsigned ctx,
            int unsigned n, int unsigned entry, logic [15:0] ev, logic [15:0] word,
            longint bytes);
        t_result r;
        logic [15:0] tab [16];
        int unsigned s, nb, got;
        r.symbol = 0;
        r.read_value = 0;
        r.status = ST_OK;
        case (kind)
            KIND_LOAD, KIND_READ: begin
                if (entry > SLOTS) begin
                    r.status = ST_BAD;
                end else if (kind == KIND_LOAD) begin
                    if (entry == SLOTS) begin
                        cnt_mem[ctx] = ev[5:0];
                        cnt_set[ctx] = 1;
                    end else begin
                        cdf_mem[ctx*SLOTS + entry] = ev;
                        cdf_set[ctx*SLOTS + entry] = 1;
                    end
                end else begin
                    r.read_value = (entry == SLOTS) ? 16'(cnt_mem[ctx])
                                                    : cdf_mem[ctx*SLOTS + entry];
                end
            end
            KIND_PUSH: begin
                if (bit_cnt + 16 > 64) begin
                    r.status = ST_FULL;
                end else begin
                    bit_buf = (bit_buf << 16) | {48'd0, word};
                    bit_cnt += 16;
                end
            end
            KIND_INIT: begin
                nb = bytes * 8 < 15 ? int'(bytes * 8) : 15;
                if (nb > bit_cnt) begin
                    r.status = ST_SHORT;
                end else begin
                    got = pull_bits(nb);
                    val_q = (32'h7FFF ^ (got << (15 - nb))) & 32'hFFFF;
                    rng_q = 32'h8000;
                    bits_left = bytes * 8 - 15;
                end
            end
            KIND_SYM: begin
                if (n < 2 || n > MAX_SYMBOLS) begin
                    r.status = ST_BAD;
                end else begin
                    for (int i = 0; i < 16; i++) tab[i] = cdf_mem[ctx*SLOTS + i];
                    if (decode_sym(tab, n, s)) begin
                        r.status = ST_SHORT;
                    end else begin
                        r.symbol = s[3:0];
                        if (!no_adapt) adapt_table(ctx, n, s);
                    end
                end
            end
            KIND_BOOL: begin
                for (int i = 0; i < 16; i++) tab[i] = 16'h0;
                tab[0] = HALF_Q15;
                tab[1] = ONE_Q15;
                if (decode_sym(tab, 2, s)) r.status = ST_SHORT;
                else r.symbol = s[3:0];
            end
            default: r.status = ST_BAD;
        endcase
        r.buffered_bits = bit_cnt[6:0];
        return r;
    endfunction

    task automatic send_word(logic [2:0] kind, logic [9:0] ctx, logic [4:0] n,
            logic [4:0] entry, logic [15:0] ev, logic [15:0] word, logic [23:0] bytes);
        bit held;
        while ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_kind <= kind;
        i_context_req <= ctx;
        i_num_symbols <= n;
        i_entry_index <= entry;
        i_entry_value <= ev;
        i_bit_word <= word;
        i_tile_bytes <= bytes;
        do begin
            @(negedge i_clk);
            held = busy;
            @(posedge i_clk);
        end while (held);
        expected_q.push_back(predict_word(kind, 32'(ctx), 32'(n), 32'(entry), ev, word,
                                          longint'(bytes)));
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        wait (expected_q.size() == 0);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic set_adapt_mode(bit off);
        bit rdy;
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= off;
        do begin
            @(negedge i_clk);
            rdy = o_cfg_ready;
            @(posedge i_clk);
        end while (!rdy);
        i_cfg_valid <= 1'b0;
        no_adapt = off;
    endtask

    // result checker: the strobed word is sampled mid-cycle
    always @(negedge i_clk) begin
        t_result e;
        if (i_rst_n && o_valid) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result word");
                errors++;
            end else begin
                e = expected_q.pop_front();
                if (o_symbol !== e.symbol) begin
                    $error("symbol exp %0d got %0d", e.symbol, o_symbol);
                    errors++;
                end
                if (o_read_value !== e.read_value) begin
                    $error("read_value exp %0d got %0d", e.read_value, o_read_value);
                    errors++;
                end
                if (o_status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_status);
                    errors++;
                end
                if (o_buffered_bits !== e.buffered_bits) begin
                    $error("buffered_bits exp %0d got %0d", e.buffered_bits,
                           o_buffered_bits);
                    errors++;
                end
            end
        end
    end

    task automatic test_table_setup();
        int unsigned v;
        foreach (ctx_pool[p]) begin
            v = 0;
            for (int i = 0; i < 15; i++) begin
                v += $urandom_range(1, (32768 - v) / (16 - i));
                send_word(KIND_LOAD, 10'(ctx_pool[p]), 5'($urandom), 5'(i), 16'(v),
                          16'($urandom), 24'($urandom));
            end
            send_word(KIND_LOAD, 10'(ctx_pool[p]), 5'($urandom), 5'd15, ONE_Q15,
                      16'($urandom), 24'($urandom));
            send_word(KIND_LOAD, 10'(ctx_pool[p]), 5'($urandom), 5'(SLOTS),
                      16'($urandom), 16'($urandom), 24'($urandom));
        end
    endtask

    task automatic test_corner_words();
        send_word(KIND_BOOL, 0, 0, 0, 0, 0, 0);                // decode straight from reset
        send_word(KIND_INIT, 0, 0, 0, 0, 0, 24'hFFFFFF);       // short buffer
        send_word(KIND_SYM, 0, 16, 0, 0, 0, 0);
        for (int i = 0; i < 5; i++)                            // last one overflows
            send_word(KIND_PUSH, 0, 0, 0, 0, (i == 0) ? 16'hFFFF : 16'(i), 0);
        send_word(KIND_INIT, 0, 0, 0, 0, 0, 0);
        send_word(KIND_INIT, 0, 0, 0, 0, 0, 24'hFFFFFF);
        send_word(KIND_SYM, 1023, 16, 0, 0, 0, 0);
        send_word(KIND_SYM, 1, 2, 0, 0, 0, 0);
        send_word(KIND_BOOL, 0, 0, 0, 0, 0, 0);
        send_word(3'd6, 0, 0, 0, 0, 0, 0);
        send_word(3'd7, 10'h3FF, 5'h1F, 5'h1F, 16'hFFFF, 16'hFFFF, 24'hFFFFFF);
        send_word(KIND_LOAD, 5, 0, 17, 16'h1234, 0, 0);
        send_word(KIND_READ, 5, 0, 31, 0, 0, 0);
        send_word(KIND_SYM, 0, 0, 0, 0, 0, 0);
        send_word(KIND_SYM, 0, 1, 0, 0, 0, 0);
        send_word(KIND_SYM, 0, 17, 0, 0, 0, 0);
        send_word(KIND_SYM, 0, 31, 0, 0, 0, 0);
        send_word(KIND_LOAD, 1022, 0, 3, 16'hFFFF, 0, 0);
        send_word(KIND_LOAD, 1022, 0, 4, ONE_Q15, 0, 0);
        send_word(KIND_LOAD, 1022, 0, 5'(SLOTS), 16'hFFFF, 0, 0);
        send_word(KIND_READ, 1022, 0, 3, 0, 0, 0);
        send_word(KIND_READ, 1022, 0, 4, 0, 0, 0);
        send_word(KIND_READ, 1022, 0, 5'(SLOTS), 0, 0, 0);
        send_word(KIND_READ, 0, 0, 5'(SLOTS), 0, 0, 0);
    endtask

    task automatic random_word();
        logic [2:0]  kind;
        logic [9:0]  ctx;
        logic [4:0]  n, entry;
        logic [15:0] ev, word;
        logic [23:0] bytes;
        int unsigned r;
        kind = 3'($urandom); ctx = 10'($urandom); n = 5'($urandom); entry = 5'($urandom);
        ev = 16'($urandom); word = 16'($urandom); bytes = 24'($urandom);
        r = $urandom_range(99);
        if (r < 22) begin
            kind = KIND_PUSH;
        end else if (r < 27) begin
            kind = KIND_INIT;
            r = $urandom_range(9);
            if (r < 7) bytes = 24'($urandom_range(12));
            else if (r < 9) bytes = 24'($urandom_range(400, 13));
        end else if (r < 62) begin
            kind = KIND_SYM;
            ctx = 10'(ctx_pool[$urandom_range(3)]);
            n = 5'($urandom_range(16, 2));
        end else if (r < 72) begin
            kind = KIND_BOOL;
        end else if (r < 80) begin
            kind = KIND_LOAD;
            entry = 5'($urandom_range(SLOTS));
            if ($urandom_range(9) < 7) ctx = 10'(ctx_pool[$urandom_range(3)]);
        end else if (r < 92) begin
            kind = KIND_READ;
            entry = 5'($urandom_range(SLOTS));
            if (entry == SLOTS ? !cnt_set[ctx] : !cdf_set[ctx*SLOTS + entry])
                ctx = 10'(ctx_pool[$urandom_range(3)]);
        end else begin
            case ($urandom_range(2))
                0: kind = 3'($urandom_range(7, 6));
                1: begin
                    kind = 3'($urandom_range(32'(KIND_READ)));
                    entry = 5'($urandom_range(31, 17));
                end
                default: begin
                    kind = KIND_SYM;
                    n = 5'($urandom_range(1) ? $urandom_range(1) : $urandom_range(31, 17));
                end
            endcase
        end
        send_word(kind, ctx, n, entry, ev, word, bytes);
    endtask

    task automatic test_random_stream(int pct, int count);
        gap_pct = pct;
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) wait_idle();   // sender holds off until drained
            random_word();
        end
    endtask

    initial begin
        rng_q = 32'h8000; val_q = 0; bit_cnt = 0; bits_left = 0; bit_buf = 0;
        no_adapt = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_adapt_mode(1'b0);
        test_table_setup();
        test_corner_words();
        test_random_stream(22, 200);
        set_adapt_mode(1'b1);
        test_random_stream(47, 170);
        set_adapt_mode(1'b0);
        test_random_stream(0, 230);
        wait_idle();
        if (errors == 0) $display("tb_top passed");
        else $display("tb_top failed");
        $finish;
    end

    initial begin
        #5ms;
        $display("tb_top failed");
        $finish;
    end
endmodule
